>>> hw/rtl/rdp_pkg.sv
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared constants for the 3D polyline simplifier.
// ----------------------------------------------------------------------------
package rdp_pkg;

  // Default capacity of the point store.
  localparam int MAX_POINTS_DEF = 64;

  // Default width of one signed coordinate.
  localparam int COORD_BITS_DEF = 24;

  // Width of the tolerance register.
  localparam int TOL_W = 23;

  // Width of the point index on the output channel.
  localparam int IDX_OUT_W = 6;

  // Multiplier bits retired per cycle by the shift-add multiplier.
  localparam int MUL_DIGIT = 4;

endpackage

>>> hw/rtl/rdp_ram.sv
// ----------------------------------------------------------------------------
// rdp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rdp_mul.sv
// ----------------------------------------------------------------------------
// rdp_mul
// Unsigned shift-add multiplier that retires a few multiplier bits per cycle.
// ----------------------------------------------------------------------------
module rdp_mul #(
  parameter int OP_W = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OP_W-1:0]   a_i,
  input  logic [OP_W-1:0]   b_i,
  output logic              done_o,
  output logic [2*OP_W-1:0] prod_o
);

  localparam int DIG   = rdp_pkg::MUL_DIGIT;
  localparam int STEPS = (OP_W + DIG - 1) / DIG;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [2*OP_W-1:0] acc_q;
  logic [2*OP_W-1:0] ash_q;
  logic [OP_W-1:0]   b_q;

  // Control: count the steps and flag completion for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Datapath: add one shifted partial product per step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ash_q <= (2*OP_W)'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_q + ash_q * (2*OP_W)'(b_q[DIG-1:0]);
      ash_q <= ash_q << DIG;
      b_q   <= b_q >> DIG;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> hw/rtl/polyline_simplifier_3d.sv
// ----------------------------------------------------------------------------
// polyline_simplifier_3d
// Ramer-Douglas-Peucker simplifier for a path of 3D points.
// ----------------------------------------------------------------------------
// Usage: points arrive on the input channel (in_valid_i / in_stall_o), one per
// transaction, and are written to the point RAM as they are accepted. The
// transaction flagged final_point_i starts simplification; in_stall_o stays
// high until the last kept point has left. Kept points leave in path order on
// the output channel (out_valid_o / out_stall_i), run_end_o on the last one.
// Points beyond MAX_POINTS are dropped and raise truncated_o for the path.
// Each segment costs 5 products (4 for a zero-length one), each interior
// point of a segment 9 products (3 for a zero-length segment). Products run
// one at a time on the single shared shift-add multiplier, which sets the run
// time. Emission passes ST_EMIT and ST_EMITR for a dropped index and ST_EMIT,
// ST_EMITR and ST_EMITW for a kept point; a stall holds the output register
// as it is. The segment stack lives in a second RAM. Keep flags ride in a
// spare bit of the point RAM and are cleared as each point loads. Reset
// empties the path and clears tolerance; cfg_we_i writes tolerance from
// cfg_wdata_i; the user must do so only while idle, as the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module polyline_simplifier_3d #(
  parameter int MAX_POINTS = rdp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = rdp_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rdp_pkg::TOL_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  x_pos_i,
  input  logic signed [COORD_BITS-1:0]  y_pos_i,
  input  logic signed [COORD_BITS-1:0]  z_pos_i,
  input  logic                          final_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS-1:0]  out_x_o,
  output logic signed [COORD_BITS-1:0]  out_y_o,
  output logic signed [COORD_BITS-1:0]  out_z_o,
  output logic [rdp_pkg::IDX_OUT_W-1:0] point_index_o,
  output logic                          run_end_o,
  output logic                          truncated_o
);

  localparam int CB    = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int D     = CB + 1;
  localparam int TW    = rdp_pkg::TOL_W;
  localparam int T2W   = 2 * TW;
  localparam int AW    = 2 * D;
  localparam int PW    = AW + 1;
  localparam int MW    = (AW > T2W) ? AW : T2W;
  localparam int NUM_W = 4 * D + 2;
  localparam int THR_W = T2W + AW;
  localparam int CMP_W = (NUM_W > THR_W) ? NUM_W : THR_W;
  localparam int PT_W  = 3 * CB;
  localparam int PR_W  = PT_W + 1;
  localparam int SEG_W = 2 * IDX_W;
  localparam int OW    = rdp_pkg::IDX_OUT_W;

  // Sequencer state codes.
  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_POP    = 4'd2;
  localparam logic [3:0] ST_POPW   = 4'd3;
  localparam logic [3:0] ST_GETS   = 4'd4;
  localparam logic [3:0] ST_GETE   = 4'd5;
  localparam logic [3:0] ST_SEGMUL = 4'd6;
  localparam logic [3:0] ST_PTGET  = 4'd7;
  localparam logic [3:0] ST_PTMUL  = 4'd8;
  localparam logic [3:0] ST_PTCMP  = 4'd9;
  localparam logic [3:0] ST_DECIDE = 4'd10;
  localparam logic [3:0] ST_PUSH2  = 4'd11;
  localparam logic [3:0] ST_EMIT   = 4'd12;
  localparam logic [3:0] ST_EMITR  = 4'd13;
  localparam logic [3:0] ST_EMITW  = 4'd14;

  function automatic logic [D-1:0] abs_d(logic signed [D-1:0] v);
    return v[D-1] ? D'(-v) : D'(v);
  endfunction

  // Control state.
  logic [3:0]            state_q;
  logic [CNT_W-1:0]      count_q;
  logic                  ovf_q;
  logic [TW-1:0]         tol_q;
  logic [CNT_W-1:0]      sp_q;
  logic [CNT_W-1:0]      idx_q;
  logic [2:0]            op_q;
  logic [1:0]            j_q;
  logic                  mbusy_q;

  // Segment and point datapath registers.
  logic [IDX_W-1:0]       s_q, e_q, i_q, best_q;
  logic signed [CB-1:0]   sx_q, sy_q, sz_q;
  logic signed [CB-1:0]   bx_q, by_q, bz_q;
  logic signed [D-1:0]    abx_q, aby_q, abz_q;
  logic signed [D-1:0]    apx_q, apy_q, apz_q;
  logic                   zl_q;
  logic [AW-1:0]          absq_q;
  logic [T2W-1:0]         tol2_q;
  logic [CMP_W-1:0]       thr_q, num_q, maxv_q;
  logic signed [PW-1:0]   p1_q;
  logic [AW-1:0]          cmag_q;

  // Output register.
  logic                 out_valid_q;
  logic signed [CB-1:0] out_x_q, out_y_q, out_z_q;
  logic [OW-1:0]        out_idx_q;
  logic                 out_end_q, out_trunc_q;

  // Memory and multiplier connections.
  logic              pt_we;
  logic              pt_mark;
  logic              pt_wen;
  logic [IDX_W-1:0]  pt_waddr;
  logic [PR_W-1:0]   pt_wdata;
  logic [IDX_W-1:0]  pt_raddr;
  logic [PR_W-1:0]   pt_rdata;
  logic              stk_we;
  logic [SEG_W-1:0]  stk_wdata;
  logic [IDX_W-1:0]  stk_raddr;
  logic [SEG_W-1:0]  stk_rdata;
  logic              mul_start, mul_done;
  logic [MW-1:0]     mul_a, mul_b;
  logic [2*MW-1:0]   mul_prod;

  logic signed [CB-1:0] rd_x, rd_y, rd_z;
  logic                 emit_keep;
  logic [IDX_W-1:0]     stk_s, stk_e;
  logic [IDX_W-1:0]     i_nx;
  logic                 accept;
  logic                 split;
  logic                 push_hi, push_lo;
  logic signed [D-1:0]  ab_u, ab_v, ap_u, ap_v, ab_k, ap_k;
  logic signed [PW-1:0] pval, cval;
  logic                 pneg;

  assign rd_x  = pt_rdata[CB-1:0];
  assign rd_y  = pt_rdata[2*CB-1:CB];
  assign rd_z  = pt_rdata[3*CB-1:2*CB];
  assign stk_s = stk_rdata[IDX_W-1:0];
  assign stk_e = stk_rdata[SEG_W-1:IDX_W];
  assign i_nx  = i_q + IDX_W'(1);

  // The path ends are always kept; other points carry a keep bit in the RAM.
  assign emit_keep = pt_rdata[PT_W] || (idx_q == '0) || (idx_q == count_q - CNT_W'(1));

  assign accept = in_valid_i && (state_q == ST_LOAD);
  assign pt_we  = accept && (count_q < CNT_W'(MAX_POINTS));

  // Split decision and the two pushes that follow from it.
  assign split   = (best_q != s_q) && (maxv_q > thr_q);
  assign push_hi = (IDX_W + 1)'(e_q) > (IDX_W + 1)'(best_q) + (IDX_W + 1)'(1);
  assign push_lo = (IDX_W + 1)'(best_q) > (IDX_W + 1)'(s_q) + (IDX_W + 1)'(1);

  // Point RAM write port: loading stores a point with its keep bit clear, a
  // split writes the furthest point back with its keep bit set.
  assign pt_mark  = (state_q == ST_DECIDE) && split;
  assign pt_wen   = pt_we || pt_mark;
  assign pt_waddr = pt_mark ? best_q : count_q[IDX_W-1:0];
  assign pt_wdata = pt_mark ? {1'b1, bz_q, by_q, bx_q} : {1'b0, z_pos_i, y_pos_i, x_pos_i};

  // Stack write port.
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = {stk_e, stk_s};
    case (state_q)
      ST_START: begin
        stk_we    = count_q > CNT_W'(2);
        stk_wdata = {IDX_W'(count_q - CNT_W'(1)), IDX_W'(0)};
      end
      ST_DECIDE: begin
        stk_we    = split && push_hi && (sp_q < CNT_W'(MAX_POINTS));
        stk_wdata = {e_q, best_q};
      end
      ST_PUSH2: begin
        stk_we    = push_lo && (sp_q < CNT_W'(MAX_POINTS));
        stk_wdata = {best_q, s_q};
      end
      default: ;
    endcase
  end

  assign stk_raddr = IDX_W'(sp_q - CNT_W'(1));

  // Point read address.
  always_comb begin
    case (state_q)
      ST_POPW:   pt_raddr = stk_s;
      ST_GETS:   pt_raddr = e_q;
      ST_SEGMUL: pt_raddr = s_q + IDX_W'(1);
      ST_PTCMP:  pt_raddr = i_nx;
      default:   pt_raddr = idx_q[IDX_W-1:0];
    endcase
  end

  // Cross-product operand selection for component op_q.
  always_comb begin
    case (op_q)
      3'd0: begin
        ab_u = aby_q; ab_v = abz_q; ap_u = apy_q; ap_v = apz_q;
        ab_k = abx_q; ap_k = apx_q;
      end
      3'd1: begin
        ab_u = abz_q; ab_v = abx_q; ap_u = apz_q; ap_v = apx_q;
        ab_k = aby_q; ap_k = apy_q;
      end
      default: begin
        ab_u = abx_q; ab_v = aby_q; ap_u = apx_q; ap_v = apy_q;
        ab_k = abz_q; ap_k = apz_q;
      end
    endcase
  end

  // Multiplier operands.
  always_comb begin
    mul_a = MW'(abs_d(ab_k));
    mul_b = MW'(abs_d(ab_k));
    pneg  = 1'b0;
    if (state_q == ST_SEGMUL) begin
      if (op_q == 3'd3) begin
        mul_a = MW'(tol_q);
        mul_b = MW'(tol_q);
      end else if (op_q == 3'd4) begin
        mul_a = MW'(tol2_q);
        mul_b = MW'(absq_q);
      end
    end else if (zl_q) begin
      mul_a = MW'(abs_d(ap_k));
      mul_b = MW'(abs_d(ap_k));
    end else begin
      case (j_q)
        2'd0: begin
          mul_a = MW'(abs_d(ab_u));
          mul_b = MW'(abs_d(ap_v));
          pneg  = ab_u[D-1] ^ ap_v[D-1];
        end
        2'd1: begin
          mul_a = MW'(abs_d(ab_v));
          mul_b = MW'(abs_d(ap_u));
          pneg  = ab_v[D-1] ^ ap_u[D-1];
        end
        default: begin
          mul_a = MW'(cmag_q);
          mul_b = MW'(cmag_q);
        end
      endcase
    end
  end

  assign mul_start = ((state_q == ST_SEGMUL) || (state_q == ST_PTMUL)) && !mbusy_q;

  // Signed partial product and cross component.
  assign pval = pneg ? -$signed({1'b0, mul_prod[AW-1:0]}) : $signed({1'b0, mul_prod[AW-1:0]});
  assign cval = p1_q - pval;

  // Sequencer and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      tol_q       <= '0;
      sp_q        <= '0;
      idx_q       <= '0;
      op_q        <= '0;
      j_q         <= '0;
      mbusy_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (stk_we) begin
        sp_q <= sp_q + CNT_W'(1);
      end
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (pt_we) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (final_point_i) begin
              state_q <= ST_START;
            end
          end
        end
        ST_START: begin
          idx_q <= '0;
          if (count_q == '0) begin
            ovf_q   <= 1'b0;
            sp_q    <= '0;
            state_q <= ST_LOAD;
          end else begin
            state_q <= (count_q > CNT_W'(2)) ? ST_POP : ST_EMIT;
          end
        end
        ST_POP: begin
          if (sp_q == '0) begin
            idx_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            sp_q    <= sp_q - CNT_W'(1);
            state_q <= ST_POPW;
          end
        end
        ST_POPW: begin
          if ((CNT_W'(stk_e) >= count_q) ||
              ((IDX_W + 1)'(stk_e) <= (IDX_W + 1)'(stk_s) + (IDX_W + 1)'(1))) begin
            state_q <= ST_POP;
          end else begin
            state_q <= ST_GETS;
          end
        end
        ST_GETS: state_q <= ST_GETE;
        ST_GETE: begin
          op_q    <= '0;
          state_q <= ST_SEGMUL;
        end
        ST_SEGMUL: begin
          if (!mbusy_q) begin
            mbusy_q <= 1'b1;
          end else if (mul_done) begin
            mbusy_q <= 1'b0;
            if ((op_q == 3'd4) || ((op_q == 3'd3) && zl_q)) begin
              state_q <= ST_PTGET;
            end else begin
              op_q <= op_q + 3'd1;
            end
          end
        end
        ST_PTGET: begin
          op_q    <= '0;
          j_q     <= '0;
          state_q <= ST_PTMUL;
        end
        ST_PTMUL: begin
          if (!mbusy_q) begin
            mbusy_q <= 1'b1;
          end else if (mul_done) begin
            mbusy_q <= 1'b0;
            if (zl_q || (j_q == 2'd2)) begin
              j_q <= '0;
              if (op_q == 3'd2) begin
                state_q <= ST_PTCMP;
              end else begin
                op_q <= op_q + 3'd1;
              end
            end else begin
              j_q <= j_q + 2'd1;
            end
          end
        end
        ST_PTCMP: begin
          state_q <= (i_nx == e_q) ? ST_DECIDE : ST_PTGET;
        end
        ST_DECIDE: begin
          if (split) begin
            state_q <= ST_PUSH2;
          end else begin
            state_q <= ST_POP;
          end
        end
        ST_PUSH2: state_q <= ST_POP;
        ST_EMIT: begin
          if (idx_q == count_q) begin
            count_q <= '0;
            ovf_q   <= 1'b0;
            sp_q    <= '0;
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_EMITR;
          end
        end
        ST_EMITR: begin
          if (emit_keep) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_EMITW;
          end else begin
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= ST_EMIT;
          end
        end
        ST_EMITW: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            idx_q       <= idx_q + CNT_W'(1);
            state_q     <= ST_EMIT;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_POPW: begin
        s_q <= stk_s;
        e_q <= stk_e;
      end
      ST_GETS: begin
        sx_q <= rd_x;
        sy_q <= rd_y;
        sz_q <= rd_z;
      end
      ST_GETE: begin
        abx_q <= D'(rd_x) - D'(sx_q);
        aby_q <= D'(rd_y) - D'(sy_q);
        abz_q <= D'(rd_z) - D'(sz_q);
        zl_q  <= (rd_x == sx_q) && (rd_y == sy_q) && (rd_z == sz_q);
      end
      ST_SEGMUL: begin
        if (mbusy_q && mul_done) begin
          case (op_q)
            3'd0: absq_q <= mul_prod[AW-1:0];
            3'd1, 3'd2: absq_q <= absq_q + mul_prod[AW-1:0];
            3'd3: begin
              tol2_q <= mul_prod[T2W-1:0];
              thr_q  <= CMP_W'(mul_prod[T2W-1:0]);
            end
            default: thr_q <= CMP_W'(mul_prod);
          endcase
          if ((op_q == 3'd4) || ((op_q == 3'd3) && zl_q)) begin
            i_q    <= s_q + IDX_W'(1);
            best_q <= s_q;
            maxv_q <= '0;
          end
        end
      end
      ST_PTGET: begin
        apx_q <= D'(rd_x) - D'(sx_q);
        apy_q <= D'(rd_y) - D'(sy_q);
        apz_q <= D'(rd_z) - D'(sz_q);
        num_q <= '0;
      end
      ST_PTMUL: begin
        if (mbusy_q && mul_done) begin
          if (zl_q || (j_q == 2'd2)) begin
            num_q <= num_q + CMP_W'(mul_prod);
          end else if (j_q == 2'd0) begin
            p1_q <= pval;
          end else begin
            cmag_q <= cval[PW-1] ? AW'(-cval) : AW'(cval);
          end
        end
      end
      ST_PTCMP: begin
        // The furthest point's coordinates are rebuilt from its offset.
        if (num_q > maxv_q) begin
          maxv_q <= num_q;
          best_q <= i_q;
          bx_q   <= CB'(apx_q + D'(sx_q));
          by_q   <= CB'(apy_q + D'(sy_q));
          bz_q   <= CB'(apz_q + D'(sz_q));
        end
        i_q <= i_nx;
      end
      ST_EMITR: begin
        out_x_q     <= rd_x;
        out_y_q     <= rd_y;
        out_z_q     <= rd_z;
        out_idx_q   <= OW'(idx_q);
        out_end_q   <= (idx_q == count_q - CNT_W'(1));
        out_trunc_q <= ovf_q;
      end
      default: ;
    endcase
  end

  // Point store with a keep bit per entry.
  rdp_ram #(
    .WIDTH (PR_W),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_wen),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  // Segment stack.
  rdp_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_POINTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sp_q[IDX_W-1:0]),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Shared multiplier.
  rdp_mul #(
    .OP_W (MW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign in_stall_o    = (state_q != ST_LOAD);
  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign point_index_o = out_idx_q;
  assign run_end_o     = out_end_q;
  assign truncated_o   = out_trunc_q;

endmodule

>>> hw/rtl/rdp_checker.sv
// ----------------------------------------------------------------------------
// rdp_checker
// Port-level checks for the polyline simplifier, bound to the top level.
// ----------------------------------------------------------------------------
module rdp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          final_point_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rdp_pkg::IDX_OUT_W-1:0] point_index_o,
  input logic                          run_end_o
);

  // No new point is taken while a result is on offer.
  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(point_index_o) && $stable(run_end_o)))
    else $error("stalled result changed");

  // A non-final point keeps the block loading.
  a_load_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !final_point_i) |=> !in_stall_o)
    else $error("block stopped loading after a non-final point");

  // The final point starts the run.
  a_final_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && final_point_i) |=> in_stall_o)
    else $error("final point did not start simplification");

  // After the last result the block returns to loading.
  a_run_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && run_end_o) |=> ##1 !in_stall_o)
    else $error("block did not return to loading after the last result");

endmodule

bind polyline_simplifier_3d rdp_checker u_rdp_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the 3D polyline simplifier: paths of points are streamed in,
// a scoreboard predicts the kept points with exact wide arithmetic, and every
// output transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int NPTS = rdp_pkg::MAX_POINTS_DEF;
  localparam int CB   = rdp_pkg::COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int HOLD_CYCLES = 20000;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [rdp_pkg::TOL_W-1:0] tol_t;

  typedef struct {
    coord_t                       x, y, z;
    logic [rdp_pkg::IDX_OUT_W-1:0] idx;
    logic                         run_end;
    logic                         trunc;
  } kept_pt_t;

  // Scoreboard: holds the path being loaded and predicts the kept points.
  class rdp_scoreboard;
    coord_t               px[NPTS], py[NPTS], pz[NPTS];
    bit                   keep[NPTS];
    int                   count;
    bit                   overflow;
    tol_t                 tol;
    kept_pt_t             kept_q[$];
    int                   errors;

    function new();
      count = 0; overflow = 0; tol = '0; errors = 0;
      foreach (keep[i]) keep[i] = 0;
    endfunction

    function longint cd(int i, int k);
      case (k)
        0: return longint'(px[i]);
        1: return longint'(py[i]);
        default: return longint'(pz[i]);
      endcase
    endfunction

    // Iterative Ramer-Douglas-Peucker over the stored points.
    function void run_rdp();
      int seg_s[NPTS], seg_e[NPTS];
      int sd;
      int s, e, best, u, v;
      longint ab[3], ap[3], c;
      logic [127:0] tol2, absq, num, maxv, thr, w;
      bit zero_len;
      tol2 = 128'(tol) * 128'(tol);
      seg_s[0] = 0; seg_e[0] = count - 1;
      sd = 1;
      while (sd > 0) begin
        sd--;
        s = seg_s[sd]; e = seg_e[sd];
        if (e <= s + 1) continue;
        zero_len = 1; absq = '0;
        for (int k = 0; k < 3; k++) begin
          ab[k] = cd(e, k) - cd(s, k);
          if (ab[k] != 0) zero_len = 0;
          w = 128'(ab[k] < 0 ? -ab[k] : ab[k]);
          absq += w * w;
        end
        best = s; maxv = '0;
        for (int i = s + 1; i < e; i++) begin
          num = '0;
          for (int k = 0; k < 3; k++) ap[k] = cd(i, k) - cd(s, k);
          for (int k = 0; k < 3; k++) begin
            if (zero_len) c = ap[k];
            else begin
              u = (k + 1) % 3; v = (k + 2) % 3;
              c = ab[u] * ap[v] - ab[v] * ap[u];
            end
            w = 128'(c < 0 ? -c : c);
            num += w * w;
          end
          if (num > maxv) begin
            maxv = num; best = i;
          end
        end
        thr = zero_len ? tol2 : tol2 * absq;
        if (best != s && maxv > thr) begin
          keep[best] = 1;
          // Stack the right half first so the left half is walked first.
          if (e > best + 1) begin
            seg_s[sd] = best; seg_e[sd] = e; sd++;
          end
          if (best > s + 1) begin
            seg_s[sd] = s; seg_e[sd] = best; sd++;
          end
        end
      end
    endfunction

    // Note one accepted input transaction.
    function void note_point(coord_t x, coord_t y, coord_t z, bit fin);
      int last;
      kept_pt_t r;
      if (count < NPTS) begin
        px[count] = x; py[count] = y; pz[count] = z;
        count++;
      end else overflow = 1;
      if (!fin) return;
      if (count > 0) begin
        keep[0] = 1; keep[count-1] = 1;
        if (count > 2) run_rdp();
        last = 0;
        for (int i = 0; i < count; i++) if (keep[i]) last = i;
        for (int i = 0; i < count; i++) begin
          if (!keep[i]) continue;
          r.x = px[i]; r.y = py[i]; r.z = pz[i];
          r.idx = i[rdp_pkg::IDX_OUT_W-1:0];
          r.run_end = (i == last);
          r.trunc = overflow;
          kept_q = {kept_q, r};
        end
      end
      foreach (keep[i]) keep[i] = 0;
      count = 0; overflow = 0;
    endfunction

    // Check one accepted output transaction.
    function void check_result(kept_pt_t got);
      kept_pt_t exp_r;
      if (kept_q.size() == 0) begin
        $error("unexpected output point index %0d", got.idx);
        errors++;
        return;
      end
      exp_r = kept_q.pop_front();
      if (got.x !== exp_r.x) begin
        $error("out_x expected %0d actual %0d", exp_r.x, got.x); errors++;
      end
      if (got.y !== exp_r.y) begin
        $error("out_y expected %0d actual %0d", exp_r.y, got.y); errors++;
      end
      if (got.z !== exp_r.z) begin
        $error("out_z expected %0d actual %0d", exp_r.z, got.z); errors++;
      end
      if (got.idx !== exp_r.idx) begin
        $error("point_index expected %0d actual %0d", exp_r.idx, got.idx); errors++;
      end
      if (got.run_end !== exp_r.run_end) begin
        $error("run_end expected %0d actual %0d", exp_r.run_end, got.run_end); errors++;
      end
      if (got.trunc !== exp_r.trunc) begin
        $error("truncated expected %0d actual %0d", exp_r.trunc, got.trunc); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  tol_t cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  coord_t x_pos = '0, y_pos = '0, z_pos = '0;
  logic final_point = 0;
  logic out_valid;
  logic out_stall = 0;
  coord_t out_x, out_y, out_z;
  logic [rdp_pkg::IDX_OUT_W-1:0] point_index;
  logic run_end, truncated;

  rdp_scoreboard sb = new();
  int snd_idle = 0, rcv_idle = 0;
  bit hold_go = 0;
  int hold_cnt = 0;
  int items_sent = 0;
  longint cycles = 0;

  polyline_simplifier_3d u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .x_pos_i(x_pos), .y_pos_i(y_pos), .z_pos_i(z_pos), .final_point_i(final_point),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z),
    .point_index_o(point_index), .run_end_o(run_end), .truncated_o(truncated)
  );

  always #4 clk = ~clk;

  // Run-length guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Receiver stall, including one long hold-off counted here.
  always @(negedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    kept_pt_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_x; got.y = out_y; got.z = out_z;
      got.idx = point_index; got.run_end = run_end; got.trunc = truncated;
      sb.check_result(got);
    end
  end

  // Send one point transaction; valid stays high afterwards.
  task automatic send_point(coord_t x, coord_t y, coord_t z, bit fin);
    @(negedge clk);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    x_pos <= x; y_pos <= y; z_pos <= z; final_point <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_point(x, y, z, fin);
    items_sent++;
    if (items_sent < 150) begin
      snd_idle = 28; rcv_idle = 87;
    end else if (items_sent < 300) begin
      snd_idle = 87; rcv_idle = 28;
    end else begin
      snd_idle = 0; rcv_idle = 0;
    end
  endtask

  // Wait until every predicted point has left, then settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.kept_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_tol(tol_t t);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_wdata <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.tol = t;
  endtask

  // Random path: full range, noisy line, or repeated points.
  task automatic send_path(int len, int kind, int noise);
    int bx, by, bz, dx, dy, dz;
    coord_t fx, fy, fz;
    bx = $urandom_range(0, 2000000) - 1000000;
    by = $urandom_range(0, 2000000) - 1000000;
    bz = $urandom_range(0, 2000000) - 1000000;
    dx = $urandom_range(0, 20000) - 10000;
    dy = $urandom_range(0, 20000) - 10000;
    dz = $urandom_range(0, 20000) - 10000;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: begin
          fx = coord_t'($urandom); fy = coord_t'($urandom); fz = coord_t'($urandom);
        end
        1: begin
          fx = coord_t'(bx + i * dx + int'($urandom_range(0, 2 * noise)) - noise);
          fy = coord_t'(by + i * dy + int'($urandom_range(0, 2 * noise)) - noise);
          fz = coord_t'(bz + i * dz + int'($urandom_range(0, 2 * noise)) - noise);
        end
        default: begin
          fx = coord_t'(bx + int'($urandom_range(0, 2)) * noise);
          fy = coord_t'(by + int'($urandom_range(0, 2)) * noise);
          fz = coord_t'(bz);
        end
      endcase
      // Occasionally close the path on its base point (bx, by, bz).
      if (i == len - 1 && kind != 0 && $urandom_range(3) == 0) begin
        fx = coord_t'(bx); fy = coord_t'(by); fz = coord_t'(bz);
      end
      send_point(fx, fy, fz, i == len - 1);
    end
  endtask

  initial begin
    int len, kind, noise, npath;
    tol_t t;
    snd_idle = 28; rcv_idle = 87;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: coordinate extremes, short paths, collinear, zero-length, ties.
    write_tol('0);
    send_point(-24'sd8388608, 24'sd8388607, -24'sd8388608, 0);
    send_point(24'sd8388607, -24'sd8388608, 24'sd8388607, 0);
    send_point(-24'sd8388608, -24'sd8388608, -24'sd8388608, 1);
    send_point(24'sd5, 24'sd6, 24'sd7, 1);
    send_point(24'sd1, 24'sd2, 24'sd3, 0);
    send_point(-24'sd1, -24'sd2, -24'sd3, 1);
    send_point(0, 0, 0, 0);
    send_point(24'sd10, 24'sd10, 24'sd10, 0);
    send_point(24'sd20, 24'sd20, 24'sd20, 1);
    // Closed path: the ends coincide.
    send_point(24'sd100, 0, 0, 0);
    send_point(24'sd300, 0, 0, 0);
    send_point(24'sd100, 24'sd50, 0, 0);
    send_point(24'sd100, 0, 0, 1);
    // Two interior points at the same distance.
    send_point(0, 0, 0, 0);
    send_point(24'sd10, 24'sd40, 0, 0);
    send_point(24'sd20, -24'sd40, 0, 0);
    send_point(24'sd30, 0, 0, 1);
    write_tol({rdp_pkg::TOL_W{1'b1}});
    send_point(24'sd8388607, 24'sd8388607, 24'sd8388607, 0);
    send_point(-24'sd8388608, 24'sd8388607, 0, 0);
    send_point(0, -24'sd8388608, 24'sd8388607, 0);
    send_point(-24'sd8388608, -24'sd8388608, -24'sd8388608, 1);
    write_tol(23'd40);
    send_point(0, 0, 0, 0);
    send_point(24'sd10, 24'sd40, 0, 0);
    send_point(24'sd30, 0, 0, 1);

    // Random paths.
    npath = 0;
    while (items_sent < 450) begin
      npath++;
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: t = '0;
          1: t = {rdp_pkg::TOL_W{1'b1}};
          2: t = tol_t'($urandom_range(0, 3000));
          default: t = tol_t'($urandom);
        endcase
        write_tol(t);
      end
      if (npath == 3) hold_go = 1'b1;
      if (npath == 10) drain();
      noise = (sb.tol == '0) ? $urandom_range(0, 3) : int'(sb.tol) % 4000 + 1;
      kind = ($urandom_range(9) < 2) ? 0 : (($urandom_range(9) == 0) ? 2 : 1);
      if (npath % 25 == 7) len = 64 + $urandom_range(0, 6);
      else if ($urandom_range(9) == 0) len = $urandom_range(1, 2);
      else len = $urandom_range(3, 10);
      send_path(len, kind, noise);
    end

    // Drain and report.
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.kept_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rdp_pkg.sv
hw/rtl/rdp_ram.sv
hw/rtl/rdp_mul.sv
hw/rtl/polyline_simplifier_3d.sv
hw/rtl/rdp_checker.sv
tb/tb.sv
